@@ rtl/gdith_pkg.sv @@
// Shared types, constants and dither helpers for the gradient pixel generator.
// No dependencies; imported by every module of the block.
package gdith_pkg;

  localparam int CH_BITS        = 8;
  localparam int NUM_CH         = 3;
  localparam int COLOR_BITS     = CH_BITS * NUM_CH;
  localparam int HEIGHT_BITS    = 11;
  localparam int CFG_IDX_BITS   = 2;
  localparam int PIXEL_BITS     = 16;
  localparam int COORD_BITS_DEF = 10;

  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(240);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TOP    = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // Register view handed to the datapath.
  typedef struct packed {
    logic [COLOR_BITS-1:0]  top;
    logic [COLOR_BITS-1:0]  bottom;
    logic [HEIGHT_BITS-1:0] divisor;
  } gdith_cfg_t;

  // Per-item side data that rides along the divider.
  typedef struct packed {
    logic [COLOR_BITS-1:0] top;
    logic [NUM_CH-1:0]     neg;    // bottom < top for that channel
    logic signed [3:0]     d_rb;   // -4..3
    logic signed [2:0]     d_g;    // -2..1
  } gdith_ctx_t;

  // Bayer 8x8, indexed {row[2:0], col[2:0]}.
  localparam logic [5:0] BAYER [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  // (d*8)/64 truncated toward zero, d = table - 32
  function automatic logic signed [3:0] dith_rb(input logic [2:0] r, input logic [2:0] c);
    logic signed [6:0] d;
    logic [6:0]        m;
    logic signed [3:0] res;
    d = $signed({1'b0, BAYER[{r, c}]}) - 7'sd32;
    m = 7'(-d);
    if (d < 0) begin
      res = -$signed({1'b0, m[5:3]});
    end else begin
      res = $signed({1'b0, d[5:3]});
    end
    return res;
  endfunction

  // (d*4)/64 truncated toward zero
  function automatic logic signed [2:0] dith_g(input logic [2:0] r, input logic [2:0] c);
    logic signed [6:0] d;
    logic [6:0]        m;
    logic signed [2:0] res;
    d = $signed({1'b0, BAYER[{r, c}]}) - 7'sd32;
    m = 7'(-d);
    if (d < 0) begin
      res = -$signed({1'b0, m[5:4]});
    end else begin
      res = $signed({1'b0, d[5:4]});
    end
    return res;
  endfunction

endpackage

@@ rtl/gdith_front.sv @@
// Front end: channel differences, dither offsets, then |bottom-top| * row.
// Two elastic register stages. Depends on gdith_pkg.
module gdith_front
  import gdith_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  gdith_cfg_t                                cfg,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [COORD_BITS-1:0]                     col,
  input  logic [COORD_BITS-1:0]                     row,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [NUM_CH-1:0][CH_BITS+COORD_BITS-1:0] out_prod,
  output gdith_ctx_t                                out_ctx
);

  localparam int PW = CH_BITS + COORD_BITS;

  // stage A
  logic                            a_vld;
  gdith_ctx_t                      a_ctx;
  logic [NUM_CH-1:0][CH_BITS-1:0]  a_mag;
  logic [COORD_BITS-1:0]           a_row;
  // stage B
  logic                            b_vld;
  gdith_ctx_t                      b_ctx;
  logic [NUM_CH-1:0][PW-1:0]       b_prod;

  logic       rdy_a, rdy_b;
  gdith_ctx_t ctx_next;
  logic [NUM_CH-1:0][CH_BITS-1:0] mag_next;

  assign rdy_b    = !b_vld || out_ready;
  assign rdy_a    = !a_vld || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    logic [CH_BITS-1:0] ta, tb;
    ctx_next.top  = cfg.top;
    ctx_next.d_rb = dith_rb(row[2:0], col[2:0]);
    ctx_next.d_g  = dith_g(row[2:0], col[2:0]);
    for (int i = 0; i < NUM_CH; i++) begin
      ta = cfg.top[i*CH_BITS +: CH_BITS];
      tb = cfg.bottom[i*CH_BITS +: CH_BITS];
      ctx_next.neg[i] = tb < ta;
      mag_next[i]     = (tb < ta) ? (ta - tb) : (tb - ta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (rdy_a) a_vld <= in_valid;
      if (rdy_b) b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_ctx <= ctx_next;
      a_mag <= mag_next;
      a_row <= row;
    end
    if (rdy_b) begin
      b_ctx <= a_ctx;
      for (int i = 0; i < NUM_CH; i++) begin
        b_prod[i] <= PW'(a_mag[i]) * PW'(a_row);
      end
    end
  end

  assign out_valid = b_vld;
  assign out_prod  = b_prod;
  assign out_ctx   = b_ctx;

endmodule

@@ rtl/gdith_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, three channel lanes.
// Divisor comes from the config registers; the user must keep it stable while
// items are in flight, the block does not enforce it. Depends on gdith_pkg.
module gdith_div
  import gdith_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [HEIGHT_BITS-1:0]                    divisor,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [NUM_CH-1:0][CH_BITS+COORD_BITS-1:0] in_prod,
  input  gdith_ctx_t                                in_ctx,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [NUM_CH-1:0][CH_BITS+COORD_BITS-1:0] out_quot,
  output gdith_ctx_t                                out_ctx
);

  localparam int PW = CH_BITS + COORD_BITS;
  localparam int NS = PW;
  localparam int DW = HEIGHT_BITS;

  logic [NS-1:0]                 vld;
  logic [NS:0]                   rdy;
  gdith_ctx_t                    ctx [NS];
  // acc shifts numerator bits out the top and quotient bits in the bottom
  logic [NUM_CH-1:0][PW-1:0]     acc [NS];
  logic [NUM_CH-1:0][DW-1:0]     rem [NS];

  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                      p_vld;
    gdith_ctx_t                p_ctx;
    logic [NUM_CH-1:0][PW-1:0] p_acc;
    logic [NUM_CH-1:0][DW-1:0] p_rem;
    logic [NUM_CH-1:0][PW-1:0] n_acc;
    logic [NUM_CH-1:0][DW-1:0] n_rem;

    if (s == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_ctx = in_ctx;
      assign p_acc = in_prod;
      assign p_rem = '0;
    end else begin : g_rest
      assign p_vld = vld[s-1];
      assign p_ctx = ctx[s-1];
      assign p_acc = acc[s-1];
      assign p_rem = rem[s-1];
    end

    assign rdy[s] = !vld[s] || rdy[s+1];

    always_comb begin
      logic [DW:0] t;
      logic        ge;
      for (int l = 0; l < NUM_CH; l++) begin
        t        = {p_rem[l], p_acc[l][PW-1]};
        ge       = t >= {1'b0, divisor};
        n_rem[l] = ge ? DW'(t - {1'b0, divisor}) : t[DW-1:0];
        n_acc[l] = {p_acc[l][PW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        ctx[s] <= p_ctx;
        acc[s] <= n_acc;
        rem[s] <= n_rem;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_quot  = acc[NS-1];
  assign out_ctx   = ctx[NS-1];

endmodule

@@ rtl/gdith_back.sv @@
// Back end: apply sign, add top color and dither, clamp, pack RGB565.
// One output register stage. Depends on gdith_pkg.
module gdith_back
  import gdith_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [NUM_CH-1:0][CH_BITS+COORD_BITS-1:0] in_quot,
  input  gdith_ctx_t                                in_ctx,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [PIXEL_BITS-1:0]                     out_pixel
);

  localparam int PW = CH_BITS + COORD_BITS;
  localparam int TW = PW + 2;

  logic                           vld;
  logic [PIXEL_BITS-1:0]          pixel;
  logic [NUM_CH-1:0][CH_BITS-1:0] chan;
  logic [PIXEL_BITS-1:0]          pixel_next;

  assign in_ready = !vld || out_ready;

  always_comb begin
    logic signed [TW-1:0] qs;
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] dz;
    for (int i = 0; i < NUM_CH; i++) begin
      qs = $signed({2'b00, in_quot[i]});
      if (in_ctx.neg[i]) qs = -qs;
      // lane 1 is green
      dz = (i == 1) ? TW'(in_ctx.d_g) : TW'(in_ctx.d_rb);
      t  = qs + $signed(TW'(in_ctx.top[i*CH_BITS +: CH_BITS])) + dz;
      if (t < 0) begin
        chan[i] = '0;
      end else if (t > $signed(TW'(255))) begin
        chan[i] = '1;
      end else begin
        chan[i] = t[CH_BITS-1:0];
      end
    end
    pixel_next = {chan[2][7:3], chan[1][7:2], chan[0][7:3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) pixel <= pixel_next;
  end

  assign out_valid = vld;
  assign out_pixel = pixel;

endmodule

@@ rtl/gradient_ordered_dither_rgb565_top.sv @@
// Vertical gradient pixel generator with 8x8 ordered dither, RGB565 output.
// Takes one item (column, row) per clock when nothing stalls and returns one
// pixel per item. The pipeline is two front stages, one divider stage per
// product bit (8 + COORD_BITS) and one output register; the bit-serial
// divider makes up most of that depth. Throughput stays one item per cycle
// while nothing stalls; every stage holds its item under back-pressure. Config
// writes are taken every cycle and should land while no item is in flight.
// Depends on gdith_pkg, gdith_front, gdith_div, gdith_back.
module gradient_ordered_dither_rgb565_top
  import gdith_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]               cfg_index,
  input  logic [COLOR_BITS-1:0]                 cfg_data,
  // pixel coordinates in
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,   // column, row
  // pixels out
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [PIXEL_BITS-1:0]                 m_tdata    // pixel
);

  localparam int PW = CH_BITS + COORD_BITS;

  logic [COLOR_BITS-1:0]  top_color;
  logic [COLOR_BITS-1:0]  bottom_color;
  logic [HEIGHT_BITS-1:0] panel_height;
  gdith_cfg_t             cfg;

  logic                      f_valid, f_ready;
  logic [NUM_CH-1:0][PW-1:0] f_prod;
  gdith_ctx_t                f_ctx;
  logic                      d_valid, d_ready;
  logic [NUM_CH-1:0][PW-1:0] d_quot;
  gdith_ctx_t                d_ctx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_color    <= '0;
      bottom_color <= '0;
      panel_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOP:    top_color    <= cfg_data;
        REG_BOTTOM: bottom_color <= cfg_data;
        REG_HEIGHT: panel_height <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.top     = top_color;
  assign cfg.bottom  = bottom_color;
  assign cfg.divisor = (panel_height > HEIGHT_BITS'(1)) ?
                       (panel_height - HEIGHT_BITS'(1)) : HEIGHT_BITS'(1);

  gdith_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .col       (s_tdata[COORD_BITS-1:0]),
    .row       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_prod  (f_prod),
    .out_ctx   (f_ctx)
  );

  gdith_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .divisor   (cfg.divisor),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_prod   (f_prod),
    .in_ctx    (f_ctx),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_quot  (d_quot),
    .out_ctx   (d_ctx)
  );

  gdith_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_quot   (d_quot),
    .in_ctx    (d_ctx),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pixel (m_tdata)
  );

endmodule

@@ rtl/gdith_checker.sv @@
// Port-level checks for the gradient pixel generator, bound to the top level.
// Depends on gdith_pkg.
module gdith_checker
  import gdith_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [PIXEL_BITS-1:0]         m_tdata
);

  // output register comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("pixel valid right after reset");

  // a taken output frees every stage, so input side must be open
  a_ready_chain: assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input stalled while output is being drained");

  // empty output register cannot stall the pipeline
  a_empty_open: assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with no pending pixel");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled pixel changed or dropped");

endmodule

bind gradient_ordered_dither_rgb565_top gdith_checker u_gdith_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ test/tb_gradient_ordered_dither_rgb565_top.sv @@
// Testbench for gradient_ordered_dither_rgb565_top: directed and random pixel coordinates
// against an in-bench gradient/dither predictor, with random source and sink idling.
// Depends on gdith_pkg and the RTL of the block; self-contained otherwise.
module tb_gradient_ordered_dither_rgb565_top;
  import gdith_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int TDATA_W    = ((2*COORD_BITS+7)/8)*8;
  localparam int PAD_BITS   = TDATA_W - 2*COORD_BITS;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int LATENCY    = COORD_BITS + 11;
  localparam int LONG_HOLD  = 400;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam int DITHER_TAB [8][8] = '{
    '{ 0, 32,  8, 40,  2, 34, 10, 42},
    '{48, 16, 56, 24, 50, 18, 58, 26},
    '{12, 44,  4, 36, 14, 46,  6, 38},
    '{60, 28, 52, 20, 62, 30, 54, 22},
    '{ 3, 35, 11, 43,  1, 33,  9, 41},
    '{51, 19, 59, 27, 49, 17, 57, 25},
    '{15, 47,  7, 39, 13, 45,  5, 37},
    '{63, 31, 55, 23, 61, 29, 53, 21}
  };

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COLOR_BITS-1:0]   cfg_data  = '0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [TDATA_W-1:0]      s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [PIXEL_BITS-1:0]   m_tdata;

  // predictor copy of the registers
  logic [COLOR_BITS-1:0]  grad_top    = '0;
  logic [COLOR_BITS-1:0]  grad_bottom = '0;
  logic [HEIGHT_BITS-1:0] grad_height = HEIGHT_BITS'(240);

  logic [PIXEL_BITS-1:0] pixel_exp [$];
  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_token   = 0;

  gradient_ordered_dither_rgb565_top #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // column [9:0], row [19:10], zero pad above
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)     // pixel [15:0]
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [PIXEL_BITS-1:0] gradient_pixel(
      input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row);
    int div, d, d_rb, d_g, a, b, v;
    logic [7:0] ch [3];
    div  = (grad_height > 1) ? int'(grad_height) - 1 : 1;
    d    = DITHER_TAB[row[2:0]][col[2:0]] - 32;
    d_rb = (d * 8) / 64;
    d_g  = (d * 4) / 64;
    for (int i = 0; i < 3; i++) begin
      a = int'(grad_top[16-8*i +: 8]);
      b = int'(grad_bottom[16-8*i +: 8]);
      v = a + ((b - a) * int'(row)) / div + ((i == 1) ? d_g : d_rb);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      ch[i] = v[7:0];
    end
    return {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
  endfunction

  task automatic note_mismatch(input string what, input logic [PIXEL_BITS-1:0] want,
                               input logic [PIXEL_BITS-1:0] got);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected pixel 0x%04h, got 0x%04h", $time, what, want, got);
  endtask

  // Leaves cfg_valid high unless this is the last write of a group.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COLOR_BITS-1:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TOP:    grad_top    = data;
      REG_BOTTOM: grad_bottom = data;
      REG_HEIGHT: grad_height = data[HEIGHT_BITS-1:0];
      default: ;
    endcase
    cfg_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_gradient(input logic [COLOR_BITS-1:0] top,
                              input logic [COLOR_BITS-1:0] bottom,
                              input logic [COLOR_BITS-1:0] height_word);
    write_reg(REG_TOP, top, 1'b0);
    write_reg(REG_BOTTOM, bottom, 1'b0);
    write_reg(REG_HEIGHT, height_word, 1'b1);
  endtask

  task automatic send_coord(input logic [COORD_BITS-1:0] col,
                            input logic [COORD_BITS-1:0] row);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_BITS{1'b0}}, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixel_exp.push_back(gradient_pixel(col, row));
    items_sent++;
  endtask

  // Drop valid and wait for every pending pixel.
  task automatic wait_drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pixel_exp.size() != 0);
  endtask

  task automatic test_directed;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    // reset values: black to black, height 240
    send_coord('0, '0);
    send_coord(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX));
    wait_drain();
    set_gradient(24'hFFFFFF, 24'h000000, 24'd1024);
    send_coord('0, '0);
    send_coord(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX));
    send_coord(10'd7, 10'd7);
    send_coord(10'd3, 10'd1022);
    wait_drain();
    // single-row panel; rows past the end extrapolate and clamp both ways
    set_gradient(24'hFF00FF, 24'h00FF00, 24'd1);
    send_coord(10'd0, 10'd0);
    send_coord(10'd1, 10'd1);
    send_coord(10'd5, 10'd2);
    send_coord(10'd6, 10'd3);
    wait_drain();
    // zero height acts like one
    write_reg(REG_HEIGHT, 24'd0, 1'b1);
    send_coord(10'd2, 10'd1);
    send_coord(10'd4, 10'd6);
    wait_drain();
    // upper data bits of the height write must be dropped
    set_gradient(24'h123456, 24'hFEDCBA, 24'hFFF802);
    send_coord(10'd1, 10'd1);
    send_coord(10'd9, 10'd4);
    wait_drain();
    write_reg(REG_HEIGHT, 24'h0007FF, 1'b1);
    send_coord(10'd8, 10'd1023);
    send_coord(10'd15, 10'd512);
    wait_drain();
    // write to an index that does not exist: registers keep their values
    write_reg(REG_UNUSED, 24'hA5A5A5, 1'b1);
    send_coord(10'd3, 10'd700);
    send_coord(10'd1023, 10'd0);
    wait_drain();
  endtask

  task automatic test_random_gradients;
    logic [COLOR_BITS-1:0]  top, bottom;
    logic [HEIGHT_BITS-1:0] h;
    int row_hi;
    int src_mode [4] = '{0, 70, 0, 30};
    int snk_mode [4] = '{0, 0, 70, 30};
    for (int round = 0; round < 8; round++) begin
      case ($urandom_range(3))
        0: begin top = 24'hFFFFFF; bottom = 24'h000000; end
        1: begin top = 24'h000000; bottom = 24'hFFFFFF; end
        default: begin top = 24'($urandom); bottom = 24'($urandom); end
      endcase
      case (round)
        0: h = 11'd1024;
        1: h = 11'd1;
        2: h = 11'd0;
        3: h = 11'd2047;
        default: h = ($urandom_range(3) == 0) ? 11'($urandom_range(1024, 2))
                                                : 11'($urandom_range(64, 2));
      endcase
      set_gradient(top, bottom, {13'($urandom), h});
      src_idle_pct  = src_mode[round % 4];
      snk_stall_pct = snk_mode[round % 4];
      row_hi = (h > 1) ? int'(h) - 1 : 7;
      if (row_hi > COORD_MAX) row_hi = COORD_MAX;
      for (int n = 0; n < 220; n++) begin
        // mostly rows on the panel, some anywhere in the field
        if ($urandom_range(4) != 0)
          send_coord(COORD_BITS'($urandom_range(COORD_MAX)), COORD_BITS'($urandom_range(row_hi)));
        else
          send_coord(COORD_BITS'($urandom_range(COORD_MAX)),
                     COORD_BITS'($urandom_range(COORD_MAX)));
      end
      wait_drain();
    end
  endtask

  // Sink holds off while the source keeps offering, then the source pauses for a full drain.
  task automatic test_backpressure;
    set_gradient(24'($urandom), 24'($urandom), 24'($urandom_range(1024, 1)));
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_token++;
    for (int n = 0; n < 120; n++)
      send_coord(COORD_BITS'($urandom_range(COORD_MAX)), COORD_BITS'($urandom_range(COORD_MAX)));
    wait_drain();
    for (int n = 0; n < 40; n++)
      send_coord(COORD_BITS'($urandom_range(COORD_MAX)), COORD_BITS'($urandom_range(COORD_MAX)));
    wait_drain();
  endtask

  // sink: random stalls, plus a long hold-off each time hold_token moves
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin : pixel_check
    logic [PIXEL_BITS-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pixel_exp.size() == 0) begin
        note_mismatch("pixel with none pending", '0, m_tdata);
      end else begin
        want = pixel_exp.pop_front();
        if (m_tdata !== want) note_mismatch("pixel mismatch", want, m_tdata);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_gradients();
    test_backpressure();
    s_tvalid <= 1'b0;
    repeat (2 * LATENCY) @(posedge clk);
    while (pixel_exp.size() != 0) begin
      note_mismatch("pixel never produced", pixel_exp.pop_front(), '0);
    end
    $display("Covered %0d coordinates, %0d pixels checked, %0d register writes,",
             items_sent, results_seen, cfg_writes);
    $display("  heights 0/1/1024/2047 and random, idle and stall mixes, long sink hold-off");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ gradient_ordered_dither_rgb565_top.f @@
rtl/gdith_pkg.sv
rtl/gdith_front.sv
rtl/gdith_div.sv
rtl/gdith_back.sv
rtl/gradient_ordered_dither_rgb565_top.sv
rtl/gdith_checker.sv
test/tb_gradient_ordered_dither_rgb565_top.sv
